// ===== rtl/rcp_pkg.sv =====
// Shared types and constants for the rotor cipher with plugboard.
// Used by rcp_rotor, rcp_plugboard and rotor_cipher_with_plugboard; no dependencies.
`default_nettype none

package rcp_pkg;

   // Fixed field widths of the request and response channels.
   localparam int LetterW  = 5;
   localparam int SelW     = 2;
   localparam int KindW    = 2;
   localparam int ReqDataW = 24;
   localparam int RspDataW = 8;
   localparam int CsrW     = 2;

   // Request kinds carried on req_tuser.
   typedef enum logic [KindW-1:0] {
      KIND_CIPHER   = 2'd0,
      KIND_WIRING   = 2'd1,
      KIND_PLUG     = 2'd2,
      KIND_POSITION = 2'd3
   } req_kind_type;

   // Per-rotor update controls from the top level to one rotor.
   typedef struct packed {
      logic               wire_we;
      logic               pos_we;
      logic               step_en;
      logic [LetterW-1:0] index;
      logic [LetterW-1:0] value;
   } rotor_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/rcp_rotor.sv =====
// One rotor: forward and inverse wiring tables, position register and lookups.
// Depends on rcp_pkg.
`default_nettype none

module rcp_rotor #(
   parameter int ALPHABET_SIZE = 26
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rcp_pkg::rotor_ctrl_type     ctrl,
   input  wire logic [rcp_pkg::LetterW-1:0] fwd_in,
   output logic      [rcp_pkg::LetterW-1:0] fwd_out,
   input  wire logic [rcp_pkg::LetterW-1:0] bwd_in,
   output logic      [rcp_pkg::LetterW-1:0] bwd_out,
   output logic                             wrap
);

   localparam int IdxW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam logic [rcp_pkg::LetterW:0] SizeW = (rcp_pkg::LetterW + 1)'(ALPHABET_SIZE);

   logic [rcp_pkg::LetterW-1:0] fwd_table_ff [ALPHABET_SIZE];
   logic [rcp_pkg::LetterW-1:0] inv_table_ff [ALPHABET_SIZE];
   logic [rcp_pkg::LetterW-1:0] position_ff;
   logic [rcp_pkg::LetterW-1:0] position_in;
   logic [rcp_pkg::LetterW:0]   fwd_sum;
   logic [rcp_pkg::LetterW:0]   fwd_idx;
   logic [rcp_pkg::LetterW-1:0] inv_val;
   logic [rcp_pkg::LetterW:0]   bwd_diff;

   assign wrap = (position_ff == rcp_pkg::LetterW'(ALPHABET_SIZE - 1));

   // Forward lookup at (c + position) mod size.
   assign fwd_sum = {1'b0, fwd_in} + {1'b0, position_ff};
   assign fwd_idx = (fwd_sum >= SizeW) ? (fwd_sum - SizeW) : fwd_sum;
   assign fwd_out = fwd_table_ff[fwd_idx[IdxW-1:0]];

   // Backward lookup gives (inverse[c] - position) mod size.
   assign inv_val  = inv_table_ff[bwd_in[IdxW-1:0]];
   assign bwd_diff = {1'b0, inv_val} + SizeW - {1'b0, position_ff};
   assign bwd_out  = (bwd_diff >= SizeW) ? rcp_pkg::LetterW'(bwd_diff - SizeW)
                                         : bwd_diff[rcp_pkg::LetterW-1:0];

   always_comb begin
      position_in = position_ff;
      if (ctrl.pos_we) begin
         position_in = ctrl.value;
      end else if (ctrl.step_en) begin
         position_in = wrap ? '0 : position_ff + rcp_pkg::LetterW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
      end else begin
         position_ff <= position_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ALPHABET_SIZE; i++) begin
            fwd_table_ff[i] <= rcp_pkg::LetterW'(i);
            inv_table_ff[i] <= rcp_pkg::LetterW'(i);
         end
      end else if (ctrl.wire_we) begin
         fwd_table_ff[ctrl.index[IdxW-1:0]] <= ctrl.value;
         inv_table_ff[ctrl.value[IdxW-1:0]] <= ctrl.index;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rcp_plugboard.sv =====
// Plugboard table that serves as the reflector, with its write port.
// Depends on rcp_pkg.
`default_nettype none

module rcp_plugboard #(
   parameter int ALPHABET_SIZE = 26
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        wr_en,
   input  wire logic [rcp_pkg::LetterW-1:0] wr_index,
   input  wire logic [rcp_pkg::LetterW-1:0] wr_value,
   input  wire logic [rcp_pkg::LetterW-1:0] letter_in,
   output logic      [rcp_pkg::LetterW-1:0] letter_out
);

   localparam int IdxW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

   logic [rcp_pkg::LetterW-1:0] plug_table_ff [ALPHABET_SIZE];

   assign letter_out = plug_table_ff[letter_in[IdxW-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ALPHABET_SIZE; i++) begin
            plug_table_ff[i] <= rcp_pkg::LetterW'(i);
         end
      end else if (wr_en) begin
         plug_table_ff[wr_index[IdxW-1:0]] <= wr_value;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rotor_cipher_with_plugboard.sv =====
// Top level of the rotor cipher with plugboard: request register, rotor chain and
// response register. Depends on rcp_pkg, rcp_rotor and rcp_plugboard.
`default_nettype none

// Usage
// Requests arrive on req_* and carry a kind on req_tuser: cipher a letter, write a
// rotor wiring entry, write a plugboard entry, or set a rotor position. Every request
// produces exactly one response on rsp_*; rsp_tuser flags a cipher letter, and
// non-cipher requests answer with a zero letter.
// A request is captured in the request register, runs through the forward rotors,
// the plugboard and the backward rotors combinationally, and lands in the response
// register. rsp_tvalid rises once the request has moved into the response register,
// and a new request is taken every cycle while the receiver does not stall.
// Table writes and rotor stepping take effect when the request leaves the request
// register, so the very next request sees them.
// When the receiver stalls, the response register holds and the request register
// keeps one more request; req_tready then drops until rsp_tready returns.
// Synchronous reset empties both registers, loads identity wiring into every rotor
// and the plugboard, clears all rotor positions and sets three rotors in use.
// csr_wr_data sets the number of rotors in use; write it only while the block idles.
module rotor_cipher_with_plugboard #(
   parameter int NUM_ROTORS    = 3,
   parameter int ALPHABET_SIZE = 26
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [rcp_pkg::CsrW-1:0]     csr_wr_data,  // active_rotors
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // [4:0] letter, [6:5] rotor_sel, [11:7] entry_index, [16:12] entry_value
   input  wire logic [rcp_pkg::ReqDataW-1:0] req_tdata,
   input  wire logic [rcp_pkg::KindW-1:0]    req_tuser,    // [1:0] req_type
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [rcp_pkg::RspDataW-1:0] rsp_tdata,    // [4:0] cipher_letter
   output logic                              rsp_tuser     // [0] is_cipher
);

   localparam int LW = rcp_pkg::LetterW;
   localparam logic [LW:0] SizeW = (LW + 1)'(ALPHABET_SIZE);

   // Constant table reducing any 5-bit value modulo the alphabet size.
   logic [LW-1:0] mod_lut [2**LW];

   for (genvar i = 0; i < 2**LW; i++) begin : g_mod
      assign mod_lut[i] = LW'(i % ALPHABET_SIZE);
   end

   // Configuration register.
   logic [rcp_pkg::CsrW-1:0] active_rotors_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_rotors_ff <= rcp_pkg::CsrW'(3);
      end else if (csr_wr_en) begin
         active_rotors_ff <= csr_wr_data;
      end
   end

   // Request register.
   logic                      s1_valid_ff;
   rcp_pkg::req_kind_type     s1_kind_ff;
   logic [LW-1:0]             s1_letter_ff;
   logic [rcp_pkg::SelW-1:0]  s1_sel_ff;
   logic [LW-1:0]             s1_index_ff;
   logic [LW-1:0]             s1_value_ff;
   logic                      s1_fire;
   logic                      req_fire;

   // Response register.
   logic                      rsp_valid_ff;
   logic [LW-1:0]             rsp_letter_ff;
   logic                      rsp_is_cipher_ff;

   // The request register moves on whenever the response register is free or drains.
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   // Letters and written values are reduced modulo the alphabet size on capture.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff   <= rcp_pkg::req_kind_type'(req_tuser);
         s1_letter_ff <= mod_lut[req_tdata[4:0]];
         s1_sel_ff    <= req_tdata[6:5];
         s1_index_ff  <= req_tdata[11:7];
         s1_value_ff  <= mod_lut[req_tdata[16:12]];
      end
   end

   // Rotor chain. Rotors at or above the count in use pass the letter unchanged;
   // since they sit at the top of the chain, the backward pass skips them as well.
   logic [LW-1:0]           fwd_chain [NUM_ROTORS+1];
   logic [LW-1:0]           bwd_chain [NUM_ROTORS+1];
   logic [LW-1:0]           fwd_out   [NUM_ROTORS];
   logic [LW-1:0]           bwd_out   [NUM_ROTORS];
   logic                    wrap      [NUM_ROTORS];
   logic                    active    [NUM_ROTORS];
   logic                    step_en   [NUM_ROTORS];
   rcp_pkg::rotor_ctrl_type rotor_ctrl [NUM_ROTORS];
   logic                    index_ok;
   logic                    is_cipher;

   assign index_ok     = {1'b0, s1_index_ff} < SizeW;
   assign is_cipher    = (s1_kind_ff == rcp_pkg::KIND_CIPHER);
   assign fwd_chain[0] = s1_letter_ff;

   for (genvar r = 0; r < NUM_ROTORS; r++) begin : g_rotor
      assign active[r] = int'(active_rotors_ff) > r;

      // Odometer stepping: rotor 0 steps on every cipher request while it is in use, and each later
      // rotor in use steps when the one below it steps and wraps.
      if (r == 0) begin : g_first
         assign step_en[r] = s1_fire && is_cipher && active[r];
      end else begin : g_next
         assign step_en[r] = step_en[r-1] && wrap[r-1] && active[r];
      end

      assign rotor_ctrl[r].wire_we = s1_fire && (s1_kind_ff == rcp_pkg::KIND_WIRING)
                                     && (int'(s1_sel_ff) == r) && index_ok;
      assign rotor_ctrl[r].pos_we  = s1_fire && (s1_kind_ff == rcp_pkg::KIND_POSITION)
                                     && (int'(s1_sel_ff) == r);
      assign rotor_ctrl[r].step_en = step_en[r];
      assign rotor_ctrl[r].index   = s1_index_ff;
      assign rotor_ctrl[r].value   = s1_value_ff;

      rcp_rotor #(
         .ALPHABET_SIZE (ALPHABET_SIZE)
      ) u_rotor (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (rotor_ctrl[r]),
         .fwd_in  (fwd_chain[r]),
         .fwd_out (fwd_out[r]),
         .bwd_in  (bwd_chain[r+1]),
         .bwd_out (bwd_out[r]),
         .wrap    (wrap[r])
      );

      assign fwd_chain[r+1] = active[r] ? fwd_out[r] : fwd_chain[r];
      assign bwd_chain[r]   = active[r] ? bwd_out[r] : bwd_chain[r+1];
   end

   logic plug_we;

   assign plug_we = s1_fire && (s1_kind_ff == rcp_pkg::KIND_PLUG) && index_ok;

   rcp_plugboard #(
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_plugboard (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (plug_we),
      .wr_index   (s1_index_ff),
      .wr_value   (s1_value_ff),
      .letter_in  (fwd_chain[NUM_ROTORS]),
      .letter_out (bwd_chain[NUM_ROTORS])
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_letter_ff    <= is_cipher ? bwd_chain[0] : '0;
         rsp_is_cipher_ff <= is_cipher;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(rcp_pkg::RspDataW - LW)'(0), rsp_letter_ff};
   assign rsp_tuser  = rsp_is_cipher_ff;

`ifndef SYNTH
   // A cipher request leaving the request register shows up as a cipher response.
   a_cipher_flag: assert property (@(posedge clock) disable iff (reset)
      s1_fire && is_cipher |=> rsp_tvalid && rsp_tuser)
      else $error("cipher request did not produce a cipher response");

   // Every delivered response letter lies inside the alphabet.
   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, rsp_tdata[LW-1:0]} < SizeW))
      else $error("response letter outside the alphabet");

   // Back-pressure reaches the request side only when both registers are full
   // and the receiver is stalling.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("request side stalled without cause");

   // Non-cipher responses carry a zero letter.
   a_zero_letter: assert property (@(posedge clock) disable iff (reset)
      s1_fire && !is_cipher |=> rsp_tdata == '0)
      else $error("non-cipher response carries a letter");
`endif

endmodule

`default_nettype wire
